>>> rtl/ntm_pkg.sv
// Package for the nearest timestamp matcher.
// Holds the default sizes, field widths and result status codes.
// No dependencies; imported by the matcher top level.
package ntm_pkg;

   // Default table depth and width of the running sequence index.
   localparam int DEF_TABLE_ENTRIES = 1024;
   localparam int DEF_INDEX_BITS    = 16;

   // Fixed field widths of the stream words.
   localparam int STAMP_W  = 64;
   localparam int STATUS_W = 3;
   localparam int OUTIDX_W = 16;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MATCHED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_LATER  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TOO_FAR   = 3'd5;

   // Input word kinds carried on tuser.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

endpackage

>>> rtl/ntm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; used for the sorted stamp table of the matcher.
module ntm_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/nearest_timestamp_matcher_unit.sv
// Top level of the nearest timestamp matcher: sorted table search and insert.
// Depends on ntm_pkg and ntm_ram.
//
//   Channel  Dir  Data (low bit first)                     Side info
//   req_     in   tdata: stamp[63:0]                       tuser: opcode
//   rsp_     out  tdata: match_index[15:0], match_stamp    tuser: status[2:0]
//   csr_     in   csr_wr_data: max_distance[63:0]          csr_wr_en
//
// One word is worked at a time. Each binary search probe reads the table RAM
// (S_SEARCH), then compares (S_STEP). A query then fetches the neighbors and
// picks the nearer; an insert moves every stored entry above its place up one
// row (S_SHIFT reads, S_MOVE writes), then writes the new entry.
// The table needs no clearing after reset: the entry count bounds all reads.
// A finished result waits in the output register; a new word is accepted
// while it waits, and the next result holds until the output is free.
module nearest_timestamp_matcher_unit
   import ntm_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int INDEX_BITS    = DEF_INDEX_BITS
) (
   input  logic                clock,
   input  logic                reset,
   // Input words.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [STAMP_W-1:0]  req_tdata,  // stamp[63:0]
   input  logic                req_tuser,  // opcode
   // Result words.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [79:0]         rsp_tdata,  // match_index[15:0], match_stamp[79:16]
   output logic [STATUS_W-1:0] rsp_tuser,  // status[2:0]
   // Tolerance register.
   input  logic                csr_wr_en,
   input  logic [STAMP_W-1:0]  csr_wr_data
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int DW = INDEX_BITS + STAMP_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SEARCH = 4'd1;
   localparam logic [3:0] S_STEP   = 4'd2;
   localparam logic [3:0] S_FETCH  = 4'd3;
   localparam logic [3:0] S_CHECK  = 4'd4;
   localparam logic [3:0] S_PREV   = 4'd5;
   localparam logic [3:0] S_DIST   = 4'd6;
   localparam logic [3:0] S_PICK   = 4'd7;
   localparam logic [3:0] S_RANGE  = 4'd8;
   localparam logic [3:0] S_SHIFT  = 4'd9;
   localparam logic [3:0] S_MOVE   = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   // Control state.
   logic [3:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [INDEX_BITS-1:0] next_idx_ff, next_idx_in;
   logic [STAMP_W-1:0]    max_dist_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Working registers of the current word.
   logic                  op_ff, op_in;
   logic [STAMP_W-1:0]    key_ff, key_in;
   logic [INDEX_BITS-1:0] assigned_ff, assigned_in;
   logic [CW-1:0]         lo_ff, lo_in;
   logic [CW-1:0]         hi_ff, hi_in;
   logic [CW-1:0]         mid_ff, mid_in;
   logic [CW-1:0]         j_ff, j_in;
   logic [STAMP_W-1:0]    cur_stamp_ff, cur_stamp_in;
   logic [INDEX_BITS-1:0] cur_idx_ff, cur_idx_in;
   logic [STAMP_W-1:0]    prev_stamp_ff, prev_stamp_in;
   logic [INDEX_BITS-1:0] prev_idx_ff, prev_idx_in;
   logic                  prev_ok_ff, prev_ok_in;
   logic [STAMP_W-1:0]    dist_ff, dist_in;
   logic [STAMP_W-1:0]    back_ff, back_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [INDEX_BITS-1:0] res_idx_ff, res_idx_in;
   logic [STAMP_W-1:0]    res_stamp_ff, res_stamp_in;

   // Output register.
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [OUTIDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [STAMP_W-1:0]    rsp_stamp_ff, rsp_stamp_in;

   // Table RAM ports.
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [DW-1:0]         ram_wr_data;
   logic [AW-1:0]         ram_rd_addr;
   logic [DW-1:0]         ram_rd_data;
   logic [STAMP_W-1:0]    rd_stamp;
   logic [INDEX_BITS-1:0] rd_idx;

   logic                  req_fire;
   logic                  out_free;
   logic [CW:0]           mid_sum;
   logic [CW-1:0]         mid_now;
   logic [CW-1:0]         lo_minus1;
   logic [CW-1:0]         j_minus1;
   logic [31:0]           res_idx_wide;

   assign rd_stamp     = ram_rd_data[STAMP_W-1:0];
   assign rd_idx       = ram_rd_data[DW-1:STAMP_W];
   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign mid_sum      = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_now      = mid_sum[CW:1];
   assign lo_minus1    = lo_ff - CW'(1);
   assign j_minus1     = j_ff - CW'(1);
   assign res_idx_wide = 32'(res_idx_ff);

   ntm_ram #(
      .WIDTH(DW),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Sequencer: search, fetch neighbors, shift for insert, deliver the result.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      next_idx_in   = next_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      assigned_in   = assigned_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      j_in          = j_ff;
      cur_stamp_in  = cur_stamp_ff;
      cur_idx_in    = cur_idx_ff;
      prev_stamp_in = prev_stamp_ff;
      prev_idx_in   = prev_idx_ff;
      prev_ok_in    = prev_ok_ff;
      dist_in       = dist_ff;
      back_in       = back_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_stamp_in  = res_stamp_ff;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = j_ff[AW-1:0];
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = lo_ff[AW-1:0];

      // The consumer took the waiting result word.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_tuser;
               key_in   = req_tdata;
               lo_in    = '0;
               hi_in    = count_ff;
               if (req_tuser == OP_INSERT) begin
                  assigned_in = next_idx_ff;
                  next_idx_in = next_idx_ff + INDEX_BITS'(1);
               end
               state_in = S_SEARCH;
            end
         end
         // Probe the middle of the open range, or finish the search.
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               ram_rd_addr = mid_now[AW-1:0];
               mid_in      = mid_now;
               state_in    = S_STEP;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_STEP: begin
            if (rd_stamp < key_ff) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SEARCH;
         end
         // Read the first stamp at or after the key, if there is one.
         S_FETCH: begin
            ram_rd_addr = lo_ff[AW-1:0];
            res_idx_in  = assigned_ff;
            res_stamp_in = key_ff;
            if (lo_ff < count_ff) begin
               state_in = S_CHECK;
            end else if (op_ff == OP_QUERY) begin
               res_status_in = ST_NO_LATER;
               res_idx_in    = '0;
               res_stamp_in  = '0;
               state_in      = S_DONE;
            end else if (count_ff == CW'(TABLE_ENTRIES)) begin
               res_status_in = ST_FULL;
               state_in      = S_DONE;
            end else begin
               j_in     = count_ff;
               state_in = S_SHIFT;
            end
         end
         S_CHECK: begin
            cur_stamp_in = rd_stamp;
            cur_idx_in   = rd_idx;
            if (op_ff == OP_INSERT) begin
               if (rd_stamp == key_ff) begin
                  res_status_in = ST_DUPLICATE;
                  state_in      = S_DONE;
               end else if (count_ff == CW'(TABLE_ENTRIES)) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  j_in     = count_ff;
                  state_in = S_SHIFT;
               end
            end else begin
               ram_rd_addr = lo_minus1[AW-1:0];
               prev_ok_in  = (lo_ff != '0);
               state_in    = (lo_ff != '0) ? S_PREV : S_DIST;
            end
         end
         S_PREV: begin
            prev_stamp_in = rd_stamp;
            prev_idx_in   = rd_idx;
            state_in      = S_DIST;
         end
         // Distances to the later and the earlier neighbor.
         S_DIST: begin
            dist_in  = cur_stamp_ff - key_ff;
            back_in  = key_ff - prev_stamp_ff;
            state_in = S_PICK;
         end
         // A tie keeps the later stamp.
         S_PICK: begin
            if (prev_ok_ff && (back_ff < dist_ff)) begin
               dist_in      = back_ff;
               res_idx_in   = prev_idx_ff;
               res_stamp_in = prev_stamp_ff;
            end else begin
               res_idx_in   = cur_idx_ff;
               res_stamp_in = cur_stamp_ff;
            end
            state_in = S_RANGE;
         end
         S_RANGE: begin
            if (dist_ff > max_dist_ff) begin
               res_status_in = ST_TOO_FAR;
               res_idx_in    = '0;
               res_stamp_in  = '0;
            end else begin
               res_status_in = ST_MATCHED;
            end
            state_in = S_DONE;
         end
         // Move entries up one place from the top, then drop the new one in.
         S_SHIFT: begin
            if (j_ff > lo_ff) begin
               ram_rd_addr = j_minus1[AW-1:0];
               state_in    = S_MOVE;
            end else begin
               ram_wr_en     = 1'b1;
               ram_wr_data   = {assigned_ff, key_ff};
               count_in      = count_ff + CW'(1);
               res_status_in = ST_INSERTED;
               state_in      = S_DONE;
            end
         end
         S_MOVE: begin
            ram_wr_en = 1'b1;
            j_in      = j_minus1;
            state_in  = S_SHIFT;
         end
         // Load the output register once it is free.
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_wide[OUTIDX_W-1:0];
               rsp_stamp_in  = res_stamp_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_idx_ff  <= '0;
         max_dist_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_idx_ff  <= next_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_dist_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      assigned_ff   <= assigned_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      j_ff          <= j_in;
      cur_stamp_ff  <= cur_stamp_in;
      cur_idx_ff    <= cur_idx_in;
      prev_stamp_ff <= prev_stamp_in;
      prev_idx_ff   <= prev_idx_in;
      prev_ok_ff    <= prev_ok_in;
      dist_ff       <= dist_in;
      back_ff       <= back_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_stamp_ff  <= res_stamp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_stamp_ff  <= rsp_stamp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_stamp_ff, rsp_idx_ff};

`ifndef SYNTHESIS
   // The table never holds more entries than it has rows.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_ENTRIES))
      else $error("entry count above table depth");

   // The search range stays ordered and inside the filled part.
   a_range_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (lo_ff <= hi_ff) && (hi_ff <= count_ff))
      else $error("search range out of order");

   // The entry count only ever grows by one, and only on a completed insert.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CW'(1)) && (state_ff == S_DONE))
      else $error("entry count changed unexpectedly");

   // The table is written only while entries are moved or placed.
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_SHIFT) || (state_ff == S_MOVE))
      else $error("table written outside the insert shift");

   // Every accepted insert uses up one sequence index.
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == OP_INSERT) |=>
         next_idx_ff == $past(next_idx_ff) + INDEX_BITS'(1))
      else $error("sequence index did not advance");
`endif

endmodule

>>> verif/nearest_timestamp_matcher_unit_checker.sv
// Checker for the nearest timestamp matcher: watches the request, result and register ports.
// Keeps its own sorted table to predict every result word and compares them in order.
// Depends on ntm_pkg for field widths, word kinds and status codes.
`timescale 1ns / 100ps

module nearest_timestamp_matcher_unit_checker
   import ntm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [STAMP_W-1:0]  req_tdata,   // stamp[63:0]
   input  logic                req_tuser,   // opcode
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [79:0]         rsp_tdata,   // match_index[15:0], match_stamp[79:16]
   input  logic [STATUS_W-1:0] rsp_tuser,   // status[2:0]
   input  logic                csr_wr_en,
   input  logic [STAMP_W-1:0]  csr_wr_data,
   output int                  results_pending,
   output int                  error_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OUTIDX_W-1:0] index;
      logic [STAMP_W-1:0]  stamp;
   } match_result_t;

   // Shadow copy of the sorted table and the running sequence index.
   logic [STAMP_W-1:0]        sorted_stamp [DEF_TABLE_ENTRIES];
   logic [DEF_INDEX_BITS-1:0] sorted_seq   [DEF_TABLE_ENTRIES];
   int                        stored_count;
   logic [DEF_INDEX_BITS-1:0] seq_counter;
   logic [STAMP_W-1:0]        tolerance;
   match_result_t             awaited_matches [$];
   int                        mismatches = 0;

   // First position whose stamp is not below the key, from 0 to stored_count.
   function automatic int first_not_below(input logic [STAMP_W-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = stored_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (sorted_stamp[mid] < key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   // Works out the result of one word and updates the shadow table.
   task automatic predict_match(input logic op, input logic [STAMP_W-1:0] key,
                                output match_result_t result);
      int                        pos;
      int                        pick;
      logic [STAMP_W-1:0]        gap;
      logic [STAMP_W-1:0]        back;
      logic [DEF_INDEX_BITS-1:0] assigned;
      result = '0;
      pos = first_not_below(key);
      if (op == OP_INSERT) begin
         // Every insert uses up an index, stored or not.
         assigned = seq_counter;
         seq_counter = seq_counter + 1'b1;
         result.index = assigned[OUTIDX_W-1:0];
         result.stamp = key;
         if (pos < stored_count && sorted_stamp[pos] == key) begin
            result.status = ST_DUPLICATE;
         end else if (stored_count >= DEF_TABLE_ENTRIES) begin
            result.status = ST_FULL;
         end else begin
            for (int i = stored_count; i > pos; i--) begin
               sorted_stamp[i] = sorted_stamp[i-1];
               sorted_seq[i]   = sorted_seq[i-1];
            end
            sorted_stamp[pos] = key;
            sorted_seq[pos]   = assigned;
            stored_count++;
            result.status = ST_INSERTED;
         end
      end else if (pos >= stored_count) begin
         result.status = ST_NO_LATER;
      end else begin
         // Nearer of the later stamp and the one before it; a tie keeps the later one.
         pick = pos;
         gap = sorted_stamp[pos] - key;
         if (pos > 0) begin
            back = key - sorted_stamp[pos-1];
            if (back < gap) begin
               pick = pos - 1;
               gap = back;
            end
         end
         if (gap > tolerance) begin
            result.status = ST_TOO_FAR;
         end else begin
            result.status = ST_MATCHED;
            result.index  = sorted_seq[pick][OUTIDX_W-1:0];
            result.stamp  = sorted_stamp[pick];
         end
      end
   endtask

   // Predict on every accepted request word, compare on every accepted result word.
   always @(posedge clock) begin
      match_result_t want;
      match_result_t got;
      if (reset) begin
         stored_count = 0;
         seq_counter  = '0;
         tolerance    = '0;
         awaited_matches.delete();
      end else begin
         if (csr_wr_en) tolerance = csr_wr_data;
         if (req_tvalid && req_tready) begin
            predict_match(req_tuser, req_tdata, want);
            awaited_matches = {awaited_matches, want};
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.index  = rsp_tdata[OUTIDX_W-1:0];
            got.stamp  = rsp_tdata[OUTIDX_W +: STAMP_W];
            if (awaited_matches.size() == 0) begin
               $error("result word with nothing awaited: status %0d, index %0d, stamp %h",
                      got.status, got.index, got.stamp);
               mismatches++;
            end else begin
               want = awaited_matches.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  mismatches++;
               end
               if (got.index !== want.index) begin
                  $error("match_index: expected %0d, actual %0d", want.index, got.index);
                  mismatches++;
               end
               if (got.stamp !== want.stamp) begin
                  $error("match_stamp: expected %h, actual %h", want.stamp, got.stamp);
                  mismatches++;
               end
            end
         end
      end
      results_pending <= awaited_matches.size();
      error_count     <= mismatches;
   end

endmodule

>>> verif/nearest_timestamp_matcher_unit_test.sv
// Top of the nearest timestamp matcher testbench: clock, reset, stimulus and verdict.
// Drives request words and tolerance writes, stalls the result side at random.
// Depends on ntm_pkg, the matcher top level and the matcher checker.
`timescale 1ns / 100ps

module nearest_timestamp_matcher_unit_test;
   import ntm_pkg::*;

   localparam int                 CYCLE_LIMIT  = 25_000_000;
   localparam logic [STAMP_W-1:0] CLUSTER_BASE = 64'h8000_0000_0000_0000;
   localparam logic [STAMP_W-1:0] BELOW_FILL   = 64'hEFFF_FFFF_FFFF_FFFF;
   localparam logic [STAMP_W-1:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [STAMP_W-1:0]  req_tdata   = '0;
   logic                req_tuser   = OP_INSERT;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [79:0]         rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;
   logic                csr_wr_en   = 1'b0;
   logic [STAMP_W-1:0]  csr_wr_data = '0;

   int                  results_pending;
   int                  error_count;
   int                  cycle_count = 0;
   int                  stall_left  = 0;
   bit                  idle_on     = 1'b0;
   logic [STAMP_W-1:0]  known_stamps [$];

   nearest_timestamp_matcher_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   nearest_timestamp_matcher_unit_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .results_pending (results_pending),
      .error_count     (error_count)
   );

   // 4 ns clock.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Result side stalls in random bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [STAMP_W-1:0] rand_stamp();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [STAMP_W-1:0] pick_known();
      if (known_stamps.size() == 0) return rand_stamp();
      return known_stamps[$urandom_range(0, known_stamps.size() - 1)];
   endfunction

   // Moves a stamp up or down by a small or a wide random offset.
   function automatic logic [STAMP_W-1:0] jitter(input logic [STAMP_W-1:0] s);
      logic [STAMP_W-1:0] off;
      if ($urandom_range(0, 3) == 0) off = rand_stamp() >> $urandom_range(1, 63);
      else off = 64'($urandom_range(0, 40));
      if ($urandom_range(0, 1) == 1) return s + off;
      return s - off;
   endfunction

   // Presents one word, after a random gap if idling is on, and waits for acceptance.
   task automatic send_word(input logic op, input logic [STAMP_W-1:0] stamp);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= stamp;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_insert(input logic [STAMP_W-1:0] stamp);
      known_stamps = {known_stamps, stamp};
      send_word(OP_INSERT, stamp);
   endtask

   // Holds the sender until every awaited result word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [STAMP_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One random word: clustered stamps make duplicates and ties common.
   task automatic send_mixed();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 20) send_insert(CLUSTER_BASE + 64'($urandom_range(0, 511) * 2));
      else if (kind < 32) send_insert(rand_stamp() & BELOW_FILL);
      else if (kind < 42) send_word(OP_INSERT, pick_known());
      else if (kind < 60) send_word(OP_QUERY, CLUSTER_BASE - 20 + 64'($urandom_range(0, 1100)));
      else if (kind < 74) send_word(OP_QUERY, pick_known());
      else if (kind < 88) send_word(OP_QUERY, jitter(pick_known()));
      else send_word(OP_QUERY, rand_stamp());
   endtask

   initial begin
      logic [STAMP_W-1:0] fill_stamp;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, query before the first stamp, duplicates, tolerance 0.
      write_tolerance('0);
      send_word(OP_QUERY, '0);
      send_word(OP_QUERY, ALL_ONES);
      send_insert(64'd1000);
      send_word(OP_QUERY, '0);
      send_word(OP_QUERY, 64'd1000);
      send_word(OP_INSERT, 64'd1000);
      send_word(OP_QUERY, 64'd1001);
      drain_results();

      // Directed: tolerance boundary, tie to the later stamp, query past the last stamp.
      write_tolerance(64'd1000);
      send_word(OP_QUERY, '0);
      send_insert(64'd3000);
      send_word(OP_QUERY, 64'd2000);
      send_word(OP_QUERY, 64'd1999);
      send_word(OP_QUERY, 64'd4001);
      send_insert('0);
      send_word(OP_QUERY, '0);
      send_insert(BELOW_FILL);
      send_word(OP_QUERY, BELOW_FILL - 1);
      send_word(OP_QUERY, 64'h7000_0000_0000_0000);
      drain_results();

      // Directed: widest tolerance.
      write_tolerance(ALL_ONES);
      send_word(OP_QUERY, 64'h7777_7777_7777_7777);
      send_word(OP_QUERY, 64'hF000_0000_0000_0000);

      // Random words under several tolerance settings, idling on both sides.
      idle_on = 1'b1;
      for (int p = 0; p < 4; p++) begin
         drain_results();
         case (p)
            0: write_tolerance(64'($urandom_range(0, 8)));
            1: write_tolerance(rand_stamp());
            2: write_tolerance('0);
            default: write_tolerance(rand_stamp() >> $urandom_range(1, 63));
         endcase
         repeat (40) send_mixed();
      end

      // Fill the table with ascending stamps until it is full, with queries between.
      drain_results();
      write_tolerance(ALL_ONES);
      fill_stamp = 64'hF000_0000_0000_0000;
      for (int n = 0; n < 1040; n++) begin
         if (n == 500) send_insert(ALL_ONES);
         fill_stamp = fill_stamp + 64'($urandom_range(1, 1 << 20));
         send_insert(fill_stamp);
         if ($urandom_range(0, 9) == 0) send_word(OP_QUERY, jitter(pick_known()));
      end

      // Full table, no idling: dropped inserts, duplicates and queries.
      drain_results();
      idle_on = 1'b0;
      write_tolerance(rand_stamp() >> $urandom_range(30, 62));
      send_word(OP_QUERY, ALL_ONES);
      send_word(OP_INSERT, ALL_ONES);
      send_word(OP_INSERT, 64'hF000_0000_0000_0000);
      repeat (40) send_mixed();

      drain_results();
      repeat (64) @(posedge clock);
      if (error_count == 0 && results_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
